### rtl/matrix3_inverse_det_assert.svh
// Assertion macros for the 3x3 matrix inverse block.
// Included by the top level; no other dependencies.
`ifndef MATRIX3_INVERSE_DET_ASSERT_SVH
`define MATRIX3_INVERSE_DET_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MI3_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MI3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MI3_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define MI3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/mi3_pkg.sv
// Shared widths, types and helpers of the 3x3 matrix inverse block.
// Used by every module of the block; depends on nothing.
package mi3_pkg;
	localparam int ELEM_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int DIM        = 3;
	localparam int NLANE      = DIM * DIM;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int MINOR_W    = PROD_W + 1;
	localparam int HI_W       = MINOR_W - ELEM_W;
	localparam int DET_W      = 3 * ELEM_W + 2;
	localparam int DMAG_W     = DET_W - 1;
	localparam int NUM_W      = PROD_W + 2 * FRAC_BITS;
	localparam int DOUT_W     = (2 * ELEM_W < 64) ? 2 * ELEM_W : 64;
	localparam int LANE_DEPTH = ELEM_W + 1;
	localparam int FRONT_DEPTH = 6;

	typedef logic signed [ELEM_W-1:0]  elem_t;
	typedef logic signed [MINOR_W-1:0] minor_t;
	typedef logic signed [DET_W-1:0]   det_t;
	typedef logic [DMAG_W-1:0]         dmag_t;
	typedef logic [PROD_W-1:0]         mag_t;
	typedef logic [ELEM_W-1:0]         quo_t;

	// rows (or columns) left over when index i is struck out
	function automatic int idx_lo(input int i);
		return (i == 0) ? 1 : 0;
	endfunction

	function automatic int idx_hi(input int i);
		return (i == 2) ? 1 : 2;
	endfunction

	// clamp an unsigned quotient to the signed element range and apply sign
	function automatic elem_t sat_quo(input quo_t q, input logic ovf, input logic neg);
		logic [ELEM_W:0] mag;
		logic [ELEM_W:0] lim;
		logic [ELEM_W:0] res;
		mag = ovf ? ((ELEM_W+1)'(1) << ELEM_W) : {1'b0, q};
		lim = ((ELEM_W+1)'(1) << (ELEM_W - 1)) - (neg ? (ELEM_W+1)'(0) : (ELEM_W+1)'(1));
		if (mag > lim)
			mag = lim;
		res = neg ? ((ELEM_W+1)'(0) - mag) : mag;
		return elem_t'(res[ELEM_W-1:0]);
	endfunction
endpackage

### rtl/mi3_minors.sv
// Nine 2x2 minors of the input matrix: products in stage 1, differences in stage 2.
// Depends on mi3_pkg.
module mi3_minors (
	input  logic           clk,
	input  logic           en,
	input  mi3_pkg::elem_t a     [mi3_pkg::DIM][mi3_pkg::DIM],
	output mi3_pkg::minor_t mn_s2 [mi3_pkg::DIM][mi3_pkg::DIM],
	output mi3_pkg::elem_t a0_s2 [mi3_pkg::DIM]
);
	logic signed [mi3_pkg::PROD_W-1:0] pa_s1 [mi3_pkg::DIM][mi3_pkg::DIM];
	logic signed [mi3_pkg::PROD_W-1:0] pb_s1 [mi3_pkg::DIM][mi3_pkg::DIM];
	mi3_pkg::elem_t a0_s1 [mi3_pkg::DIM];

	for (genvar r = 0; r < mi3_pkg::DIM; r++) begin : g_row
		localparam int R0 = mi3_pkg::idx_lo(r);
		localparam int R1 = mi3_pkg::idx_hi(r);
		for (genvar c = 0; c < mi3_pkg::DIM; c++) begin : g_col
			localparam int C0 = mi3_pkg::idx_lo(c);
			localparam int C1 = mi3_pkg::idx_hi(c);
			always_ff @(posedge clk) begin
				if (en) begin
					pa_s1[r][c] <= a[R0][C0] * a[R1][C1];
					pb_s1[r][c] <= a[R0][C1] * a[R1][C0];
					mn_s2[r][c] <= mi3_pkg::minor_t'(pa_s1[r][c]) -
						mi3_pkg::minor_t'(pb_s1[r][c]);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				a0_s1[r] <= a[0][r];
				a0_s2[r] <= a0_s1[r];
			end
		end
	end
endmodule

### rtl/mi3_det.sv
// Determinant by expansion along row 0, split into partial products (stages 3 to 5).
// Depends on mi3_pkg; fed by mi3_minors.
module mi3_det (
	input  logic            clk,
	input  logic            en,
	input  mi3_pkg::minor_t mn_i  [mi3_pkg::DIM][mi3_pkg::DIM],
	input  mi3_pkg::elem_t  a0_i  [mi3_pkg::DIM],
	output mi3_pkg::det_t   det_s5,
	output mi3_pkg::minor_t mn_s5 [mi3_pkg::DIM][mi3_pkg::DIM]
);
	logic signed [mi3_pkg::PROD_W:0]               plo_s3 [mi3_pkg::DIM];
	logic signed [mi3_pkg::ELEM_W+mi3_pkg::HI_W-1:0] phi_s3 [mi3_pkg::DIM];
	mi3_pkg::det_t   term_s4 [mi3_pkg::DIM];
	mi3_pkg::minor_t mn_s3 [mi3_pkg::DIM][mi3_pkg::DIM];
	mi3_pkg::minor_t mn_s4 [mi3_pkg::DIM][mi3_pkg::DIM];

	for (genvar j = 0; j < mi3_pkg::DIM; j++) begin : g_term
		logic [mi3_pkg::ELEM_W-1:0]      lo;
		logic signed [mi3_pkg::HI_W-1:0] hi;
		assign lo = mn_i[0][j][mi3_pkg::ELEM_W-1:0];
		assign hi = $signed(mn_i[0][j][mi3_pkg::MINOR_W-1:mi3_pkg::ELEM_W]);
		always_ff @(posedge clk) begin
			if (en) begin
				plo_s3[j]  <= a0_i[j] * $signed({1'b0, lo});
				phi_s3[j]  <= a0_i[j] * hi;
				term_s4[j] <= (mi3_pkg::det_t'(phi_s3[j]) <<< mi3_pkg::ELEM_W) +
					mi3_pkg::det_t'(plo_s3[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s3  <= mn_i;
			mn_s4  <= mn_s3;
			mn_s5  <= mn_s4;
			// cofactor signs along row 0: + - +
			det_s5 <= term_s4[0] - term_s4[1] + term_s4[2];
		end
	end
endmodule

### rtl/mi3_div_lane.sv
// One divider lane: restoring division of a cofactor magnitude by |det|,
// one quotient bit per stage. Depends on mi3_pkg.
module mi3_div_lane (
	input  logic           clk,
	input  logic           en,
	input  mi3_pkg::mag_t  m,
	input  mi3_pkg::dmag_t d,
	input  logic           neg,
	output mi3_pkg::quo_t  quo,
	output logic           ovf,
	output logic           neg_o
);
	localparam int N = mi3_pkg::ELEM_W;

	mi3_pkg::dmag_t rem_s  [N+1];
	mi3_pkg::dmag_t d_s    [N+1];
	mi3_pkg::quo_t  quo_s  [N+1];
	mi3_pkg::quo_t  low_s  [N+1];
	logic           ovf_s  [N+1];
	logic           neg_s  [N+1];

	logic [mi3_pkg::NUM_W-1:0]        num;
	logic [mi3_pkg::NUM_W-N-1:0]      num_hi;
	assign num    = {m, (2 * mi3_pkg::FRAC_BITS)'(0)};
	assign num_hi = num[mi3_pkg::NUM_W-1:N];

	always_ff @(posedge clk) begin
		if (en) begin
			// quotient of 2^N or more saturates
			ovf_s[0] <= mi3_pkg::DMAG_W'(num_hi) >= d;
			rem_s[0] <= mi3_pkg::DMAG_W'(num_hi);
			low_s[0] <= num[N-1:0];
			quo_s[0] <= '0;
			d_s[0]   <= d;
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [mi3_pkg::DMAG_W:0] r2;
		logic [mi3_pkg::DMAG_W:0] diff;
		logic                     ge;
		assign r2   = {rem_s[k-1], low_s[k-1][N-1]};
		assign diff = r2 - {1'b0, d_s[k-1]};
		assign ge   = r2 >= {1'b0, d_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[mi3_pkg::DMAG_W-1:0] : r2[mi3_pkg::DMAG_W-1:0];
				quo_s[k] <= {quo_s[k-1][N-2:0], ge};
				low_s[k] <= low_s[k-1] << 1;
				d_s[k]   <= d_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign quo   = quo_s[N];
	assign ovf   = ovf_s[N];
	assign neg_o = neg_s[N];
endmodule

### rtl/matrix3_inverse_det.sv
// 3x3 matrix inverse and determinant, Q16.16 in, Q16.16 inverse and Q32.32 determinant
// out. Fully pipelined: one matrix is accepted every cycle while the output is not
// stalled, and each result passes through six front stages for minors and determinant,
// one setup stage plus one stage per quotient bit in each of nine parallel divider
// lanes, then the output register. When the result register is stalled the whole pipe
// holds. A zero determinant sets singular and zeroes the inverse and determinant.
// Depends on mi3_pkg, mi3_minors, mi3_det, mi3_div_lane and the assertion header.
`include "matrix3_inverse_det_assert.svh"
module matrix3_inverse_det (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [mi3_pkg::ELEM_W-1:0] a00, a01, a02,
	input  logic signed [mi3_pkg::ELEM_W-1:0] a10, a11, a12,
	input  logic signed [mi3_pkg::ELEM_W-1:0] a20, a21, a22,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [mi3_pkg::ELEM_W-1:0] inv00, inv01, inv02,
	output logic signed [mi3_pkg::ELEM_W-1:0] inv10, inv11, inv12,
	output logic signed [mi3_pkg::ELEM_W-1:0] inv20, inv21, inv22,
	output logic signed [mi3_pkg::DOUT_W-1:0] determinant,
	output logic singular
);
	localparam int VLD_N = mi3_pkg::FRONT_DEPTH + mi3_pkg::LANE_DEPTH;
	localparam int LD    = mi3_pkg::LANE_DEPTH;
	localparam int DW    = mi3_pkg::DMAG_W;
	localparam int OW    = mi3_pkg::DOUT_W;

	logic en;
	logic [VLD_N-1:0] vld_q;
	logic out_valid_q;

	mi3_pkg::elem_t  a [mi3_pkg::DIM][mi3_pkg::DIM];
	mi3_pkg::minor_t mn_s2 [mi3_pkg::DIM][mi3_pkg::DIM];
	mi3_pkg::elem_t  a0_s2 [mi3_pkg::DIM];
	mi3_pkg::det_t   det_s5;
	mi3_pkg::minor_t mn_s5 [mi3_pkg::DIM][mi3_pkg::DIM];

	mi3_pkg::dmag_t dmag_s6;
	logic           sing_s6;
	logic [OW-1:0]  dout_s6;
	mi3_pkg::mag_t  cofm_s6 [mi3_pkg::NLANE];
	logic           cneg_s6 [mi3_pkg::NLANE];

	logic           sing_q [LD];
	logic [OW-1:0]  dout_q [LD];

	mi3_pkg::quo_t  lq   [mi3_pkg::NLANE];
	logic           lovf [mi3_pkg::NLANE];
	logic           lneg [mi3_pkg::NLANE];

	mi3_pkg::elem_t inv_q [mi3_pkg::NLANE];
	logic [OW-1:0]  det_q;
	logic           sing_out_q;

	// advance the pipe unless the result beat is held
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	assign a[0][0] = a00; assign a[0][1] = a01; assign a[0][2] = a02;
	assign a[1][0] = a10; assign a[1][1] = a11; assign a[1][2] = a12;
	assign a[2][0] = a20; assign a[2][1] = a21; assign a[2][2] = a22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[VLD_N-2:0], in_valid};
			out_valid_q <= vld_q[VLD_N-1];
		end
	end

	mi3_minors u_minors (
		.clk   (clk),
		.en    (en),
		.a     (a),
		.mn_s2 (mn_s2),
		.a0_s2 (a0_s2)
	);

	mi3_det u_det (
		.clk    (clk),
		.en     (en),
		.mn_i   (mn_s2),
		.a0_i   (a0_s2),
		.det_s5 (det_s5),
		.mn_s5  (mn_s5)
	);

	// stage 6: |det|, truncated determinant output, cofactor magnitudes and signs
	logic           dneg;
	mi3_pkg::det_t  dabs;
	logic [DW-1:0]  dmag;
	logic [DW-1:0]  dt;
	logic [DW-1:0]  dlim;
	logic [DW-1:0]  dsat;
	logic [OW-1:0]  dout;

	always_comb begin
		dneg = det_s5[mi3_pkg::DET_W-1];
		dabs = dneg ? -det_s5 : det_s5;
		dmag = dabs[DW-1:0];
		dt   = dmag >> mi3_pkg::FRAC_BITS;
		dlim = (DW'(1) << (OW - 1)) - (dneg ? DW'(0) : DW'(1));
		dsat = (dt > dlim) ? dlim : dt;
		dout = dneg ? (OW'(0) - dsat[OW-1:0]) : dsat[OW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s6 <= dmag;
			sing_s6 <= (det_s5 == '0);
			dout_s6 <= dout;
		end
	end

	for (genvar l = 0; l < mi3_pkg::NLANE; l++) begin : g_lane
		localparam int R = l / mi3_pkg::DIM;
		localparam int C = l % mi3_pkg::DIM;
		localparam bit ODD = ((R + C) % 2) == 1;
		mi3_pkg::minor_t mn;
		mi3_pkg::minor_t mabs;
		logic            mneg;
		assign mn   = mn_s5[C][R];
		assign mneg = mn[mi3_pkg::MINOR_W-1];
		assign mabs = mneg ? -mn : mn;

		always_ff @(posedge clk) begin
			if (en) begin
				cofm_s6[l] <= mabs[mi3_pkg::PROD_W-1:0];
				// an odd place flips the minor; zero stays non-negative
				cneg_s6[l] <= (ODD ? (!mneg && mn != '0) : mneg) != dneg;
			end
		end

		mi3_div_lane u_lane (
			.clk   (clk),
			.en    (en),
			.m     (cofm_s6[l]),
			.d     (dmag_s6),
			.neg   (cneg_s6[l]),
			.quo   (lq[l]),
			.ovf   (lovf[l]),
			.neg_o (lneg[l])
		);

		always_ff @(posedge clk) begin
			if (en)
				inv_q[l] <= sing_q[LD-1] ? '0 : mi3_pkg::sat_quo(lq[l], lovf[l], lneg[l]);
		end
	end

	// carry the per-item flags alongside the divider lanes
	always_ff @(posedge clk) begin
		if (en) begin
			sing_q[0] <= sing_s6;
			dout_q[0] <= dout_s6;
			for (int i = 1; i < LD; i++) begin
				sing_q[i] <= sing_q[i-1];
				dout_q[i] <= dout_q[i-1];
			end
			sing_out_q <= sing_q[LD-1];
			det_q      <= sing_q[LD-1] ? '0 : dout_q[LD-1];
		end
	end

	assign out_valid   = out_valid_q;
	assign singular    = sing_out_q;
	assign determinant = det_q;
	assign inv00 = inv_q[0]; assign inv01 = inv_q[1]; assign inv02 = inv_q[2];
	assign inv10 = inv_q[3]; assign inv11 = inv_q[4]; assign inv12 = inv_q[5];
	assign inv20 = inv_q[6]; assign inv21 = inv_q[7]; assign inv22 = inv_q[8];

	`MI3_ASSERT_IMPLY(a_sing_zero, clk, arst_n, out_valid && singular, determinant == '0 && inv00 == '0 && inv11 == '0 && inv22 == '0, "singular beat with nonzero outputs")
	`MI3_ASSERT_NEXT(a_last_to_out, clk, arst_n, vld_q[VLD_N-1] && en, out_valid, "lane result dropped before output register")
endmodule
